// File: design/priority_round_robin_read_mux_defines.svh
// assertion macros used by the checker file
`ifndef PRIORITY_ROUND_ROBIN_READ_MUX_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_READ_MUX_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PRRM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define PRRM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/prrm_pkg.sv
// shared types and constants for the read request mux
`default_nettype none

package prrm_pkg;

	localparam int ADDR_WIDTH  = 64;
	localparam int COUNT_WIDTH = 32;
	localparam int CFG_DATA_WIDTH = 64;
	localparam int NUM_CHAN    = 4;
	localparam int CH_WIDTH    = $clog2(NUM_CHAN);
	localparam int TAG_WIDTH   = 3;

	localparam logic [CH_WIDTH-1:0] CHAN_A = 2'd0;
	localparam logic [CH_WIDTH-1:0] CHAN_B = 2'd1;
	localparam logic [CH_WIDTH-1:0] CHAN_C = 2'd2;
	localparam logic [CH_WIDTH-1:0] CHAN_D = 2'd3;

	localparam logic [TAG_WIDTH-1:0] TAG_PRIO      = 3'd1;
	localparam logic [TAG_WIDTH-1:0] TAG_CHAN_BASE = 3'd2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic                   prio_pending;
		logic [ADDR_WIDTH-1:0]  prio_addr;
		logic [COUNT_WIDTH-1:0] prio_count;
		logic [NUM_CHAN-1:0]    chan_pending;
		logic [ADDR_WIDTH-1:0]  chan_a_addr;
		logic [COUNT_WIDTH-1:0] chan_a_count;
		logic [ADDR_WIDTH-1:0]  chan_b_addr;
		logic [COUNT_WIDTH-1:0] chan_b_count;
		logic [ADDR_WIDTH-1:0]  chan_c_addr;
		logic [COUNT_WIDTH-1:0] chan_c_count;
		logic [ADDR_WIDTH-1:0]  chan_d_addr;
		logic [COUNT_WIDTH-1:0] chan_d_count;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_WIDTH-1:0]  out_addr;
		logic [COUNT_WIDTH-1:0] out_count;
		logic [TAG_WIDTH-1:0]   source_tag;
	} out_item_t;

	// granted request waiting for the offset add
	typedef struct packed {
		logic [ADDR_WIDTH-1:0]  addr;
		logic [ADDR_WIDTH-1:0]  offset;
		logic [COUNT_WIDTH-1:0] count;
		logic [TAG_WIDTH-1:0]   tag;
	} grant_t;

	// handshake between two parts
	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

endpackage

`default_nettype wire

// File: design/prrm_front.sv
// front part: offset registers, priority check and round robin grant
`default_nettype none

module prrm_front import prrm_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire in_item_t                  in_data,
	input  wire logic                      cfg_we,
	input  wire logic [CH_WIDTH-1:0]       cfg_index,
	input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data,
	output hs_t                            push,
	output grant_t                         push_data,
	input  wire logic                      push_ready
);

	logic [ADDR_WIDTH-1:0]  offset_q [NUM_CHAN];
	logic [CH_WIDTH-1:0]    last_q;
	logic [ADDR_WIDTH-1:0]  ch_addr  [NUM_CHAN];
	logic [COUNT_WIDTH-1:0] ch_count [NUM_CHAN];
	logic                   found;
	logic [CH_WIDTH-1:0]    grant_ch;
	logic                   accept;

	assign ch_addr[CHAN_A]  = in_data.chan_a_addr;
	assign ch_addr[CHAN_B]  = in_data.chan_b_addr;
	assign ch_addr[CHAN_C]  = in_data.chan_c_addr;
	assign ch_addr[CHAN_D]  = in_data.chan_d_addr;
	assign ch_count[CHAN_A] = in_data.chan_a_count;
	assign ch_count[CHAN_B] = in_data.chan_b_count;
	assign ch_count[CHAN_C] = in_data.chan_c_count;
	assign ch_count[CHAN_D] = in_data.chan_d_count;

	// search starts at the channel after the last one served
	always_comb begin
		logic [CH_WIDTH-1:0] cand;
		found    = 1'b0;
		grant_ch = last_q;
		cand     = last_q;
		for (int i = 1; i <= NUM_CHAN; i++) begin
			cand = last_q + CH_WIDTH'(i);
			if (!found && in_data.chan_pending[cand]) begin
				found    = 1'b1;
				grant_ch = cand;
			end
		end
	end

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;

	assign push.valid = in_valid && (in_data.prio_pending || found);
	assign push.ready = push_ready;

	always_comb begin
		if (in_data.prio_pending) begin
			push_data.addr   = in_data.prio_addr;
			push_data.offset = '0;
			push_data.count  = in_data.prio_count;
			push_data.tag    = TAG_PRIO;
		end else begin
			push_data.addr   = ch_addr[grant_ch];
			push_data.offset = offset_q[grant_ch];
			push_data.count  = ch_count[grant_ch];
			push_data.tag    = TAG_CHAN_BASE + TAG_WIDTH'(grant_ch);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CHAN; k++) begin
				offset_q[k] <= '0;
			end
		end else if (cfg_we) begin
			offset_q[cfg_index] <= cfg_data[ADDR_WIDTH-1:0];
		end
	end

	// a priority grant leaves the pointer alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= CHAN_A;
		end else if (accept && !in_data.prio_pending && found) begin
			last_q <= grant_ch;
		end
	end

endmodule

`default_nettype wire

// File: design/prrm_queue.sv
// short queue of granted requests between front and back
`default_nettype none

module prrm_queue import prrm_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire hs_t    push,
	input  wire grant_t push_data,
	output logic        push_ready,
	output logic        pop_valid,
	output grant_t      pop_data,
	input  wire logic   pop_ready
);

	grant_t                entry_q [QUEUE_DEPTH];
	logic [QPTR_WIDTH-1:0] wr_ptr_q;
	logic [QPTR_WIDTH-1:0] rd_ptr_q;
	logic [QCNT_WIDTH-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (count_q != QCNT_WIDTH'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];

	assign do_push = push.valid && push.ready;
	assign do_pop  = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/prrm_back.sv
// back part: offset add and output register
`default_nettype none

module prrm_back import prrm_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   pop_valid,
	input  wire grant_t pop_data,
	output logic        pop_ready,
	output logic        out_valid,
	input  wire logic   out_ready,
	output out_item_t   out_data
);

	logic      out_valid_q;
	out_item_t out_data_q;

	// refill whenever the output slot is empty or being taken
	assign pop_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			out_data_q.out_addr   <= pop_data.addr + pop_data.offset;
			out_data_q.out_count  <= pop_data.count;
			out_data_q.source_tag <= pop_data.tag;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// File: design/priority_round_robin_read_mux.sv
// top level of the read request mux: priority port plus four round robin channels
//
// channel  handshake             payload
// in       in_valid/in_ready     in_data (in_item_t)
// out      out_valid/out_ready   out_data (out_item_t)
// cfg      cfg_valid/cfg_ready   cfg_index, cfg_data (offset register write)
//
// one item per cycle sustained while the output is not stalled; grant is decided in the accept cycle
// result passes through a queue slot, then the offset add into the output register
// an item with nothing pending is taken and produces no result
// in_ready drops only when the two-entry queue is full behind a stalled output
// cfg_ready is always high; reset clears offsets, queue, output and points at channel A
`default_nettype none

module priority_round_robin_read_mux import prrm_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire in_item_t                  in_data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output out_item_t                      out_data,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CH_WIDTH-1:0]       cfg_index,
	input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data
);

	hs_t    push;
	grant_t push_data;
	logic   push_ready;
	logic   pop_valid;
	grant_t pop_data;
	logic   pop_ready;

	assign cfg_ready = 1'b1;

	prrm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	prrm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	prrm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// File: design/prrm_checker.sv
// port-level checks for the read request mux, bound to the top level
`default_nettype none

`include "priority_round_robin_read_mux_defines.svh"

module prrm_checker import prrm_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data,
	input wire logic      cfg_valid,
	input wire logic      cfg_ready
);

	// stalled result holds
	`PRRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

	// tag is one of the five sources
	`PRRM_ASSERT_NOW(a_tag_range, out_valid, out_data.source_tag >= TAG_PRIO && out_data.source_tag <= (TAG_CHAN_BASE + TAG_WIDTH'(CHAN_D)), "source tag out of range")

	// input backpressure only while a result sits unread
	`PRRM_ASSERT_NOW(a_stall_cause, !in_ready, out_valid, "input stalled with empty output")

	// configuration is never refused
	`PRRM_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

endmodule

bind priority_round_robin_read_mux prrm_checker u_prrm_checker (.*);

`default_nettype wire
